FILE: src/mtq_pkg.sv
package mtq_pkg;

  localparam int WORD_BITS = 32;
  localparam int DEPTH_DEF = 128;

  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                        mode;
    logic signed [WORD_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] dequeued_value;
    logic signed [WORD_BITS-1:0] max_value;
    logic                        queue_empty;
    status_t                     status;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_POP_WR,
    S_XFER_RD,
    S_XFER_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    push_back;
    logic    pop_rd;
    logic    pop_wr;
    logic    xfer_rd;
    logic    xfer_wr;
    logic    finish;
    status_t fin_status;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic front_empty;
    logic back_empty;
    logic back_full;
    logic back_last;
  } sts_t;

endpackage

FILE: src/mtq_ctrl.sv
module mtq_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  mtq_pkg::sts_t sts,
  output mtq_pkg::cmd_t cmd,
  output logic         busy
);
  import mtq_pkg::*;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
          st_nxt    = ST_OK;
        end
      end
      S_EXEC: begin
        if (sts.mode == MODE_ENQ) begin
          state_nxt = S_FINISH;
          if (sts.back_full) st_nxt = ST_FULL;
        end else if (!sts.front_empty) begin
          state_nxt = S_POP_RD;
        end else if (!sts.back_empty) begin
          state_nxt = S_XFER_RD;
        end else begin
          state_nxt = S_FINISH;
          st_nxt    = ST_EMPTY;
        end
      end
      S_POP_RD:  state_nxt = S_POP_WR;
      S_POP_WR:  state_nxt = S_FINISH;
      S_XFER_RD: state_nxt = S_XFER_WR;
      S_XFER_WR: state_nxt = sts.back_last ? S_POP_RD : S_XFER_RD;
      S_FINISH:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.fin_status = st_r;
    busy           = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      S_EXEC:    cmd.push_back = (sts.mode == MODE_ENQ) && !sts.back_full;
      S_POP_RD:  cmd.pop_rd = 1'b1;
      S_POP_WR:  cmd.pop_wr = 1'b1;
      S_XFER_RD: cmd.xfer_rd = 1'b1;
      S_XFER_WR: cmd.xfer_wr = 1'b1;
      S_FINISH:  cmd.finish = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

FILE: src/mtq_dp.sv
module mtq_dp #(
  parameter int DEPTH = mtq_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mtq_pkg::in_t  in_data,
  input  mtq_pkg::cmd_t cmd,
  output mtq_pkg::sts_t sts,
  output mtq_pkg::out_t out_data,
  output logic          out_valid
);
  import mtq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic signed [WORD_BITS-1:0] item;
    logic signed [WORD_BITS-1:0] prev_max;
    logic                        link_v;
    logic [IW-1:0]               link_i;
  } ent_t;

  ent_t fmem [DEPTH];
  ent_t bmem [DEPTH];
  ent_t frd_r, brd_r;

  in_t                         req_r;
  logic [CW-1:0]               fcnt_r, bcnt_r;
  logic                        fmax_v_r, bmax_v_r;
  logic [IW-1:0]               fmax_i_r, bmax_i_r;
  logic signed [WORD_BITS-1:0] fmax_r, bmax_r;
  logic signed [WORD_BITS-1:0] deq_r;
  out_t                        out_r;
  logic                        out_valid_r;

  logic [CW-1:0] ftop, btop;
  logic          b_raise, f_raise;
  ent_t          bwr, fwr;

  assign ftop    = fcnt_r - CW'(1);
  assign btop    = bcnt_r - CW'(1);
  assign b_raise = $signed(req_r.value) > bmax_r;
  assign f_raise = $signed(brd_r.item) > fmax_r;

  assign bwr = '{item: req_r.value, prev_max: bmax_r, link_v: bmax_v_r, link_i: bmax_i_r};
  assign fwr = '{item: brd_r.item, prev_max: fmax_r, link_v: fmax_v_r, link_i: fmax_i_r};

  assign sts.mode        = req_r.mode;
  assign sts.front_empty = (fcnt_r == '0);
  assign sts.back_empty  = (bcnt_r == '0);
  assign sts.back_full   = (bcnt_r == CW'(DEPTH));
  assign sts.back_last   = (bcnt_r == CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.push_back) bmem[bcnt_r[IW-1:0]] <= bwr;
    if (cmd.xfer_rd)   brd_r <= bmem[btop[IW-1:0]];
    if (cmd.xfer_wr)   fmem[fcnt_r[IW-1:0]] <= fwr;
    if (cmd.pop_rd)    frd_r <= fmem[ftop[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) req_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r      <= '0;
      bcnt_r      <= '0;
      fmax_v_r    <= 1'b0;
      bmax_v_r    <= 1'b0;
      fmax_i_r    <= '0;
      bmax_i_r    <= '0;
      fmax_r      <= WORD_MIN;
      bmax_r      <= WORD_MIN;
      deq_r       <= WORD_MIN;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.latch) deq_r <= WORD_MIN;
      if (cmd.push_back) begin
        bcnt_r <= bcnt_r + CW'(1);
        if (b_raise) begin
          bmax_v_r <= 1'b1;
          bmax_i_r <= bcnt_r[IW-1:0];
          bmax_r   <= req_r.value;
        end
      end
      if (cmd.xfer_wr) begin
        bcnt_r <= btop;
        fcnt_r <= fcnt_r + CW'(1);
        if (bcnt_r == CW'(1)) begin
          bmax_v_r <= 1'b0;
          bmax_r   <= WORD_MIN;
        end
        if (f_raise) begin
          fmax_v_r <= 1'b1;
          fmax_i_r <= fcnt_r[IW-1:0];
          fmax_r   <= brd_r.item;
        end
      end
      if (cmd.pop_wr) begin
        fcnt_r <= ftop;
        deq_r  <= frd_r.item;
        if (fmax_v_r && (fmax_i_r == ftop[IW-1:0])) begin
          fmax_v_r <= frd_r.link_v;
          fmax_i_r <= frd_r.link_i;
          fmax_r   <= frd_r.prev_max;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.dequeued_value <= deq_r;
      out_r.max_value      <= (fmax_r > bmax_r) ? fmax_r : bmax_r;
      out_r.queue_empty    <= (fcnt_r == '0) && (bcnt_r == '0);
      out_r.status         <= cmd.fin_status;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

FILE: src/max_tracking_queue.sv
// channel  ports                       transfer when
// input    start, busy, in_data        start high, busy low at the clock edge
// result   out_valid, out_data         out_valid high (one cycle, no back-pressure)
//
// enqueue: accept, EXEC, FINISH, result; the result cycle can accept again
// dequeue with nonempty front stack: EXEC, POP_RD, POP_WR, FINISH
// dequeue on an empty queue: EXEC, FINISH; with empty front, nonempty back stack:
//   one memory read then one memory write per moved entry, then the pop as above
// reset (rst_n low, synchronous) empties both stacks; no clearing pass
module max_tracking_queue #(
  parameter int DEPTH = mtq_pkg::DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  mtq_pkg::in_t in_data,
  output logic         out_valid,
  output mtq_pkg::out_t out_data
);
  import mtq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mtq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mtq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

endmodule

FILE: src/mtq_chk.sv
module mtq_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input mtq_pkg::in_t  in_data,
  input logic          out_valid,
  input mtq_pkg::out_t out_data
);
  import mtq_pkg::*;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  a_empty_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.queue_empty) |-> (out_data.max_value == WORD_MIN))
    else $error("empty queue reports a maximum");

  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL)) |-> !out_data.queue_empty)
    else $error("full refusal on empty queue");

  a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_EMPTY))
      |-> (out_data.queue_empty && (out_data.dequeued_value == WORD_MIN)))
    else $error("bad result for dequeue on empty queue");

endmodule

bind max_tracking_queue mtq_chk u_mtq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
